/* hdl/ace_pkg.sv */
package ace_pkg;

    // Table geometry
    localparam int ENTRIES = 128;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Protocol constants
    localparam logic [15:0] MAX_AGE_RESET = 16'd300;
    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] ARP_OP_REPLY  = 16'd2;

    // Item operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_FRAME  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_TICK    = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_MISS    = 3'd2;
    localparam logic [2:0] ST_STORED  = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] query_ip;
        logic [15:0] frame_ethertype;
        logic [15:0] frame_arp_opcode;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        hit;
        logic [47:0] found_mac;
    } result_t;

    typedef struct packed {
        logic load_item;
        logic scan_en;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic done;
    } dp_status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_OUT
    } ctrl_state_t;

endpackage

/* hdl/ace_item_if.sv */
interface ace_item_if;
    import ace_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] query_ip;
    logic [15:0] frame_ethertype;
    logic [15:0] frame_arp_opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;

    modport source (
        output valid, op, query_ip, frame_ethertype, frame_arp_opcode, sender_ip, sender_mac,
        input  ready
    );

    modport sink (
        input  valid, op, query_ip, frame_ethertype, frame_arp_opcode, sender_ip, sender_mac,
        output ready
    );
endinterface

/* hdl/ace_result_if.sv */
interface ace_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        hit;
    logic [47:0] found_mac;

    modport source (
        output valid, status, hit, found_mac,
        input  ready
    );

    modport sink (
        input  valid, status, hit, found_mac,
        output ready
    );
endinterface

/* hdl/ace_cfg_if.sv */
interface ace_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* hdl/ace_ctrl.sv */
module ace_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output ace_pkg::ctrl_cmd_t cmd,
    input  ace_pkg::dp_status_t sts
);
    import ace_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        item_ready    = 1'b0;
        cmd.load_item = 1'b0;
        cmd.scan_en   = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = CS_SCAN;
                end
            end
            CS_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.done)
                begin
                    state_next = CS_OUT;
                end
            end
            CS_OUT:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

/* hdl/ace_datapath.sv */
module ace_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ace_pkg::ctrl_cmd_t  cmd,
    output ace_pkg::dp_status_t sts,
    input  ace_pkg::item_t      item_in,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output ace_pkg::result_t    result_out
);
    import ace_pkg::*;

    // Entry storage: valid bits in flops, payload in memories
    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        ip_mem    [ENTRIES];
    logic [47:0]        mac_mem   [ENTRIES];
    logic [31:0]        birth_mem [ENTRIES];
    logic [31:0]        ip_rd_reg;
    logic [47:0]        mac_rd_reg;
    logic [31:0]        birth_rd_reg;

    logic [31:0] tick_count_reg;
    logic [15:0] max_age_reg;

    // Current item
    logic [1:0]  op_reg;
    logic [31:0] query_ip_reg;
    logic [31:0] sender_ip_reg;
    logic [47:0] sender_mac_reg;
    logic        scan_item_reg;

    // Scan address and evaluation stage
    logic [IDX_W-1:0] addr_reg;
    logic             issue_reg;
    logic [IDX_W-1:0] p_idx_reg;
    logic             p_vld_reg;
    logic             p_last_reg;

    result_t res_reg;
    result_t out_reg;

    logic        needs_scan;
    logic        is_reply;
    logic        issue;
    logic        act;
    logic        entry_vld;
    logic [31:0] age;
    logic        expire;
    logic        match;
    logic        slot;

    assign is_reply   = (item_in.op == OP_FRAME) &&
                        (item_in.frame_ethertype == ETHERTYPE_ARP) &&
                        (item_in.frame_arp_opcode == ARP_OP_REPLY);
    assign needs_scan = (item_in.op == OP_TICK) || (item_in.op == OP_LOOKUP) || is_reply;

    // Evaluate one entry per cycle
    assign issue     = cmd.scan_en && issue_reg;
    assign act       = cmd.scan_en && p_vld_reg && scan_item_reg;
    assign entry_vld = valid_reg[p_idx_reg];
    assign age       = tick_count_reg - birth_rd_reg;
    assign expire    = act && (op_reg == OP_TICK) && entry_vld &&
                       (age >= {16'd0, max_age_reg});
    assign match     = act && (op_reg == OP_LOOKUP) && entry_vld &&
                       (ip_rd_reg == query_ip_reg);
    assign slot      = act && (op_reg == OP_FRAME) && !entry_vld;

    assign sts.done  = (cmd.scan_en && !scan_item_reg) ||
                       (act && (p_last_reg || match || slot));

    // Memory read and write ports
    always_ff @(posedge clk)
    begin
        ip_rd_reg    <= ip_mem[addr_reg];
        mac_rd_reg   <= mac_mem[addr_reg];
        birth_rd_reg <= birth_mem[addr_reg];
        if (slot)
        begin
            ip_mem[p_idx_reg]    <= sender_ip_reg;
            mac_mem[p_idx_reg]   <= sender_mac_reg;
            birth_mem[p_idx_reg] <= tick_count_reg;
        end
    end

    // Control state: valid bits, counters, scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            tick_count_reg <= '0;
            max_age_reg    <= MAX_AGE_RESET;
            scan_item_reg  <= 1'b0;
            issue_reg      <= 1'b0;
            addr_reg       <= '0;
            p_vld_reg      <= 1'b0;
            op_reg         <= OP_TICK;
        end
        else
        begin
            if (cfg_we)
            begin
                max_age_reg <= cfg_data;
            end
            if (expire)
            begin
                valid_reg[p_idx_reg] <= 1'b0;
            end
            if (slot)
            begin
                valid_reg[p_idx_reg] <= 1'b1;
            end
            if (cmd.load_item)
            begin
                op_reg        <= item_in.op;
                scan_item_reg <= needs_scan;
                issue_reg     <= 1'b1;
                addr_reg      <= '0;
                p_vld_reg     <= 1'b0;
                if (item_in.op == OP_TICK)
                begin
                    tick_count_reg <= tick_count_reg + 32'd1;
                end
            end
            else
            begin
                p_vld_reg <= issue;
                if (issue)
                begin
                    if (addr_reg == LAST_IDX)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + IDX_W'(1);
                    end
                end
            end
        end
    end

    // Evaluation stage index tracking
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p_idx_reg  <= addr_reg;
            p_last_reg <= (addr_reg == LAST_IDX);
        end
    end

    // Item payload and result
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            query_ip_reg      <= item_in.query_ip;
            sender_ip_reg     <= item_in.sender_ip;
            sender_mac_reg    <= item_in.sender_mac;
            res_reg.hit       <= 1'b0;
            res_reg.found_mac <= '0;
            priority if (item_in.op == OP_TICK)
            begin
                res_reg.status <= ST_TICK;
            end
            else if (item_in.op == OP_LOOKUP)
            begin
                res_reg.status <= ST_MISS;
            end
            else if (is_reply)
            begin
                res_reg.status <= ST_FULL;
            end
            else
            begin
                res_reg.status <= ST_IGNORED;
            end
        end
        else if (match)
        begin
            res_reg.status    <= ST_HIT;
            res_reg.hit       <= 1'b1;
            res_reg.found_mac <= mac_rd_reg;
        end
        else if (slot)
        begin
            res_reg.status <= ST_STORED;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign result_out = out_reg;

endmodule

/* hdl/arp_cache_engine.sv */
// A lookup that hits entry k or a reply stored in free slot k gives its result once the
// scan reaches entry k; a tick, a miss or a full table scans all ENTRIES entries
// (one entry per cycle through the single memory read port); other items skip the scan.
// Throughput: one item at a time; the next item is accepted once the result is in the
// output register. Reset: valid bits clear at once, tick count 0, max age 300.
module arp_cache_engine (
    input  logic         clk,
    input  logic         rst_n,
    ace_item_if.sink     item,
    ace_result_if.source result,
    ace_cfg_if.sink      cfg
);
    import ace_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    item_t      item_in;
    result_t    result_out;

    // Gather the input item
    assign item_in.op               = item.op;
    assign item_in.query_ip         = item.query_ip;
    assign item_in.frame_ethertype  = item.frame_ethertype;
    assign item_in.frame_arp_opcode = item.frame_arp_opcode;
    assign item_in.sender_ip        = item.sender_ip;
    assign item_in.sender_mac       = item.sender_mac;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    ace_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    ace_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .item_in    (item_in),
        .cfg_we     (cfg.valid && cfg.ready),
        .cfg_data   (cfg.data),
        .result_out (result_out)
    );

    assign result.status    = result_out.status;
    assign result.hit       = result_out.hit;
    assign result.found_mac = result_out.found_mac;

    // Hit flag agrees with status
    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.hit == (result.status == ST_HIT)))
        else $error("hit flag disagrees with status");

    // Hardware address is zero unless hit
    a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.hit) |-> (result.found_mac == 48'd0))
        else $error("found_mac nonzero without hit");

    // One item at a time: busy right after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item accepted while busy");

    // Status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status <= ST_FULL))
        else $error("status code out of range");

endmodule
